/* rtl/core/expr_tok_pkg.sv */
package expr_tok_pkg;

  // Scanner modes, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_IDENT   = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_STRING  = 5'b01000,
    MODE_DISCARD = 5'b10000
  } tok_mode_e;

  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_NEWLINE = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_OPER    = 3'd5,
    KIND_ERROR   = 3'd6
  } tok_kind_e;

  // Results written into the output queue by one source beat
  typedef struct packed {
    logic first;
    logic second;
  } tok_push_t;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_A_LOW   = 8'h61;
  localparam logic [7:0] CHAR_Z_LOW   = 8'h7A;

  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

/* rtl/core/expression_tokenizer.sv */
// Expression tokenizer. Takes one source byte per beat and returns tokens: identifiers
// (runs of a..z), decimal numbers (saturating, with an overflow flag), quoted strings,
// the operators , ( ) + - * /, newlines and errors; spaces and tabs are skipped and byte 0
// ends the input with an end token, after which line and offset restart at 1 and 0. A byte
// can close an identifier or number and start another token, so it yields zero, one or two
// tokens; last_result_o marks the final token of its byte. Each byte is scanned in the cycle
// it is accepted and its tokens are written into a four-entry output queue, from which they
// leave in order. source_ready_o is high while the queue has at least two free entries,
// independent of token_ready_i. Sustained rate is one byte per clock as long as
// the downstream side takes one token per clock and bytes average at most one token each;
// the single output port of the queue sets the token rate at one per clock. After an
// unexpected character bytes are dropped without tokens until byte 0. Offsets, lengths and
// the line count saturate at their maximum.
module expression_tokenizer import expr_tok_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   source_valid_i,
  output logic                   source_ready_o,
  input  logic [7:0]             source_byte_i,
  output logic                   token_valid_o,
  input  logic                   token_ready_i,
  output logic [2:0]             token_kind_o,
  output logic [7:0]             operator_char_o,
  output logic [NUMBER_BITS-1:0] number_value_o,
  output logic                   number_overflow_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] text_length_o,
  output logic [OFFSET_BITS-1:0] line_number_o,
  output logic                   last_result_o
);

  localparam int unsigned RES_W = 3 + 8 + NUMBER_BITS + 1 + 3 * OFFSET_BITS + 1;

  // Must match the field order of the scanner's result word
  typedef struct packed {
    tok_kind_e              kind;
    logic [7:0]             opc;
    logic [NUMBER_BITS-1:0] num;
    logic                   ovf;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] line;
    logic                   last;
  } res_t;

  tok_push_t        push;
  logic [RES_W-1:0] res0, res1, head_raw;
  logic             room;
  logic             accept;
  res_t             head;

  // Take a source beat only when the queue can hold both tokens it may produce
  assign source_ready_o = room;
  assign accept         = source_valid_i && room;

  expr_tok_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .NUMBER_BITS(NUMBER_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (source_byte_i),
    .push_o  (push),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  // Output queue: holds finished tokens while the sink stalls
  expr_tok_fifo #(
    .WIDTH(RES_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data0_i(res0),
    .data1_i(res1),
    .room_o (room),
    .valid_o(token_valid_o),
    .ready_i(token_ready_i),
    .data_o (head_raw)
  );

  assign head              = head_raw;
  assign token_kind_o      = head.kind;
  assign operator_char_o   = head.opc;
  assign number_value_o    = head.num;
  assign number_overflow_o = head.ovf;
  assign start_offset_o    = head.start;
  assign text_length_o     = head.len;
  assign line_number_o     = head.line;
  assign last_result_o     = head.last;

endmodule

/* rtl/core/expr_tok_scan.sv */
module expr_tok_scan import expr_tok_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16,
  parameter int unsigned NUMBER_BITS = 32,
  localparam int unsigned RES_W = 3 + 8 + NUMBER_BITS + 1 + 3 * OFFSET_BITS + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  output tok_push_t        push_o,
  output logic [RES_W-1:0] res0_o,
  output logic [RES_W-1:0] res1_o
);

  typedef struct packed {
    tok_kind_e              kind;
    logic [7:0]             opc;
    logic [NUMBER_BITS-1:0] num;
    logic                   ovf;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] line;
    logic                   last;
  } res_t;

  localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (&v) ? v : v + OFF_ONE;
  endfunction

  tok_mode_e              mode_q, mode_d;
  logic [NUMBER_BITS-1:0] acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] len_q, len_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] line_q, line_d;

  logic is_letter, is_digit, is_oper;
  logic [NUMBER_BITS+3:0] prod;
  logic                   prod_ovf;

  assign is_letter = (byte_i >= CHAR_A_LOW) && (byte_i <= CHAR_Z_LOW);
  assign is_digit  = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign is_oper   = (byte_i == CHAR_COMMA) || (byte_i == CHAR_LPAREN) ||
                     (byte_i == CHAR_RPAREN) || (byte_i == CHAR_PLUS) ||
                     (byte_i == CHAR_MINUS) || (byte_i == CHAR_STAR) ||
                     (byte_i == CHAR_SLASH);

  // acc * 10 + digit; any bit above the number width means saturation
  assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
                (NUMBER_BITS + 4)'(byte_i[3:0]);
  assign prod_ovf = ovf_q || (|prod[NUMBER_BITS+3:NUMBER_BITS]);

  res_t r0, r1, ir;
  logic v0, v1, iv, fall, restart;

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    start_d = start_q;
    len_d   = len_q;
    pos_d   = pos_q;
    line_d  = line_q;
    r0      = '0;
    r1      = '0;
    ir      = '0;
    r0.line = line_q;
    r1.line = line_q;
    ir.line = line_q;
    v0      = 1'b0;
    v1      = 1'b0;
    iv      = 1'b0;
    fall    = 1'b0;
    restart = 1'b0;

    if (accept_i) begin
      pos_d = sat_inc(pos_q);

      unique case (mode_q)
        MODE_STRING: begin
          if (byte_i == CHAR_QUOTE) begin
            v0 = 1'b1;
            r0.kind  = KIND_STRING;
            r0.start = start_q;
            r0.len   = len_q;
            mode_d   = MODE_IDLE;
          end else if (byte_i == CHAR_NUL) begin
            // unterminated string: error, then end
            v0 = 1'b1;
            r0.kind  = KIND_ERROR;
            r0.start = start_q;
            r0.len   = len_q;
            v1 = 1'b1;
            r1.kind  = KIND_END;
            r1.start = pos_q;
            restart  = 1'b1;
          end else begin
            len_d = sat_inc(len_q);
          end
        end
        MODE_DISCARD: begin
          if (byte_i == CHAR_NUL) begin
            v0 = 1'b1;
            r0.kind  = KIND_END;
            r0.start = pos_q;
            restart  = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_letter) begin
            len_d = sat_inc(len_q);
          end else begin
            v0 = 1'b1;
            r0.kind  = KIND_IDENT;
            r0.start = start_q;
            r0.len   = len_q;
            fall     = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            acc_d = prod_ovf ? '1 : prod[NUMBER_BITS-1:0];
            ovf_d = prod_ovf;
            len_d = sat_inc(len_q);
          end else begin
            v0 = 1'b1;
            r0.kind  = KIND_NUMBER;
            r0.num   = acc_q;
            r0.ovf   = ovf_q;
            r0.start = start_q;
            r0.len   = len_q;
            fall     = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase

      // Handle the byte as between tokens
      if (fall) begin
        mode_d = MODE_IDLE;
        if (byte_i == CHAR_NUL) begin
          iv = 1'b1;
          ir.kind  = KIND_END;
          ir.start = pos_q;
          restart  = 1'b1;
        end else if (byte_i == CHAR_SPACE || byte_i == CHAR_TAB) begin
          mode_d = MODE_IDLE;
        end else if (is_letter) begin
          mode_d  = MODE_IDENT;
          start_d = pos_q;
          len_d   = OFF_ONE;
        end else if (is_digit) begin
          mode_d  = MODE_NUMBER;
          start_d = pos_q;
          len_d   = OFF_ONE;
          acc_d   = NUMBER_BITS'(byte_i[3:0]);
          ovf_d   = 1'b0;
        end else if (is_oper) begin
          iv = 1'b1;
          ir.kind  = KIND_OPER;
          ir.opc   = byte_i;
          ir.start = pos_q;
          ir.len   = OFF_ONE;
        end else if (byte_i == CHAR_NEWLINE) begin
          iv = 1'b1;
          ir.kind  = KIND_NEWLINE;
          ir.start = pos_q;
          ir.len   = OFF_ONE;
          line_d   = sat_inc(line_q);
        end else if (byte_i == CHAR_QUOTE) begin
          mode_d  = MODE_STRING;
          start_d = sat_inc(pos_q);
          len_d   = '0;
        end else begin
          iv = 1'b1;
          ir.kind  = KIND_ERROR;
          ir.opc   = byte_i;
          ir.start = pos_q;
          mode_d   = MODE_DISCARD;
        end

        if (iv) begin
          if (v0) begin
            r1 = ir;
            v1 = 1'b1;
          end else begin
            r0 = ir;
            v0 = 1'b1;
          end
        end
      end

      if (v1) begin
        r1.last = 1'b1;
      end else if (v0) begin
        r0.last = 1'b1;
      end

      // End of input: back to line 1, offset 0
      if (restart) begin
        mode_d  = MODE_IDLE;
        acc_d   = '0;
        ovf_d   = 1'b0;
        start_d = '0;
        len_d   = '0;
        pos_d   = '0;
        line_d  = OFF_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      line_q  <= OFF_ONE;
    end else begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
    end
  end

  assign push_o.first  = v0;
  assign push_o.second = v1;
  assign res0_o        = r0;
  assign res1_o        = r1;

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.second |-> push_o.first)
    else $error("second token pushed without a first");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && byte_i == CHAR_NUL) |=> (line_q == OFF_ONE && pos_q == '0 &&
                                          mode_q == MODE_IDLE))
    else $error("end of input did not restart the scanner");

endmodule

/* rtl/core/expr_tok_fifo.sv */
module expr_tok_fifo import expr_tok_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_push_t        push_i,
  input  logic [WIDTH-1:0] data0_i,
  input  logic [WIDTH-1:0] data1_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign data_o  = mem[rd_ptr_q];
  // Room for the worst case of two tokens from one beat
  assign room_o  = (count_q <= (PTR_W + 1)'(QUEUE_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_i.first) + PTR_W'(push_i.second);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign count_d  = count_q + (PTR_W + 1)'(push_i.first) + (PTR_W + 1)'(push_i.second) -
                    (PTR_W + 1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem[wr_ptr_q] <= data0_i;
    end
    if (push_i.second) begin
      mem[wr_ptr_q + PTR_W'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.first || push_i.second) |-> room_o)
    else $error("token queue pushed without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W + 1)'(QUEUE_DEPTH))
    else $error("token queue count out of range");

endmodule

/* test/testbench.sv */
module testbench;
  import expr_tok_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OFF_W = 16;
  localparam int unsigned NUM_W = 32;

  localparam logic [OFF_W-1:0] OFF_MAX = '1;
  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  // One token as it leaves the block
  typedef struct {
    tok_kind_e        kind;
    logic [7:0]       op_char;
    logic [NUM_W-1:0] value;
    logic             overflow;
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] length;
    logic [OFF_W-1:0] line;
    logic             last;
  } token_t;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             source_valid_i = 1'b0;
  logic             source_ready_o;
  logic [7:0]       source_byte_i  = 8'h00;
  logic             token_valid_o;
  logic             token_ready_i  = 1'b0;
  logic [2:0]       token_kind_o;
  logic [7:0]       operator_char_o;
  logic [NUM_W-1:0] number_value_o;
  logic             number_overflow_o;
  logic [OFF_W-1:0] start_offset_o;
  logic [OFF_W-1:0] text_length_o;
  logic [OFF_W-1:0] line_number_o;
  logic             last_result_o;

  expression_tokenizer #(
    .OFFSET_BITS(OFF_W),
    .NUMBER_BITS(NUM_W)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .source_valid_i   (source_valid_i),
    .source_ready_o   (source_ready_o),
    .source_byte_i    (source_byte_i),
    .token_valid_o    (token_valid_o),
    .token_ready_i    (token_ready_i),
    .token_kind_o     (token_kind_o),
    .operator_char_o  (operator_char_o),
    .number_value_o   (number_value_o),
    .number_overflow_o(number_overflow_o),
    .start_offset_o   (start_offset_o),
    .text_length_o    (text_length_o),
    .line_number_o    (line_number_o),
    .last_result_o    (last_result_o)
  );

  // Tokens predicted but not yet seen on the output, oldest first
  token_t      pending_tokens[$];
  token_t      seen_token;
  int unsigned errors        = 0;
  // Bytes the scanner actually looked at (discarded bytes are not counted)
  int unsigned scanned_bytes = 0;
  // Random gaps on both sides; cleared for the calm tail of the run
  bit          idle_on       = 1'b1;

  logic [7:0] oper_chars[7] = '{CHAR_COMMA, CHAR_LPAREN, CHAR_RPAREN, CHAR_PLUS,
                                CHAR_MINUS, CHAR_STAR, CHAR_SLASH};

  // ------------------------------------------------------------------
  // Scanner state mirrored by the predictor
  // ------------------------------------------------------------------
  tok_mode_e        scan_mode_q = MODE_IDLE;
  logic [NUM_W-1:0] acc_q       = '0;
  logic             acc_ovf_q   = 1'b0;
  logic [OFF_W-1:0] tok_start_q = '0;
  logic [OFF_W-1:0] tok_len_q   = '0;
  logic [OFF_W-1:0] pos_q       = '0;
  logic [OFF_W-1:0] line_q      = OFF_W'(1);

  function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  // Line is taken from the scanner at the moment the token is formed
  function automatic token_t token_of(input tok_kind_e kind, input logic [7:0] op_char,
                                      input logic [NUM_W-1:0] value, input logic overflow,
                                      input logic [OFF_W-1:0] start,
                                      input logic [OFF_W-1:0] length);
    token_t t;
    t.kind     = kind;
    t.op_char  = op_char;
    t.value    = value;
    t.overflow = overflow;
    t.start    = start;
    t.length   = length;
    t.line     = line_q;
    t.last     = 1'b0;
    return t;
  endfunction

  // Advance the mirrored scanner by one accepted byte and queue the tokens it yields
  function automatic void scan_byte(input logic [7:0] b);
    token_t             found[$];
    logic [OFF_W-1:0]   here;
    logic               restart;
    logic               consumed;
    logic               letter;
    logic               digit;
    logic               oper;
    logic [2*NUM_W-1:0] wide;

    here     = pos_q;
    restart  = 1'b0;
    consumed = 1'b0;
    letter   = (b >= CHAR_A_LOW) && (b <= CHAR_Z_LOW);
    digit    = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    oper     = 1'b0;
    foreach (oper_chars[i]) if (b == oper_chars[i]) oper = 1'b1;
    if (scan_mode_q != MODE_DISCARD) scanned_bytes++;

    case (scan_mode_q)
      MODE_STRING: begin
        // Any byte but quote and NUL belongs to the body, newline included
        if (b == CHAR_QUOTE) begin
          found.push_back(token_of(KIND_STRING, 8'h00, '0, 1'b0, tok_start_q, tok_len_q));
          scan_mode_q = MODE_IDLE;
        end else if (b == CHAR_NUL) begin
          found.push_back(token_of(KIND_ERROR, 8'h00, '0, 1'b0, tok_start_q, tok_len_q));
          found.push_back(token_of(KIND_END, 8'h00, '0, 1'b0, here, '0));
          restart = 1'b1;
        end else begin
          tok_len_q = sat_inc(tok_len_q);
        end
        consumed = 1'b1;
      end
      MODE_DISCARD: begin
        if (b == CHAR_NUL) begin
          found.push_back(token_of(KIND_END, 8'h00, '0, 1'b0, here, '0));
          restart = 1'b1;
        end
        consumed = 1'b1;
      end
      MODE_IDENT: begin
        if (letter) begin
          tok_len_q = sat_inc(tok_len_q);
          consumed  = 1'b1;
        end else begin
          found.push_back(token_of(KIND_IDENT, 8'h00, '0, 1'b0, tok_start_q, tok_len_q));
          scan_mode_q = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (digit) begin
          wide = (2*NUM_W)'(acc_q) * (2*NUM_W)'(10) + (2*NUM_W)'(b - CHAR_ZERO);
          if (acc_ovf_q || wide > (2*NUM_W)'(NUM_MAX)) begin
            acc_q     = NUM_MAX;
            acc_ovf_q = 1'b1;
          end else begin
            acc_q = wide[NUM_W-1:0];
          end
          tok_len_q = sat_inc(tok_len_q);
          consumed  = 1'b1;
        end else begin
          found.push_back(token_of(KIND_NUMBER, 8'h00, acc_q, acc_ovf_q,
                                   tok_start_q, tok_len_q));
          scan_mode_q = MODE_IDLE;
        end
      end
      default: scan_mode_q = MODE_IDLE;
    endcase

    // Handle the byte as between tokens unless the open token swallowed it
    if (!consumed) begin
      if (b == CHAR_NUL) begin
        found.push_back(token_of(KIND_END, 8'h00, '0, 1'b0, here, '0));
        restart = 1'b1;
      end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
        // skip
      end else if (letter) begin
        scan_mode_q = MODE_IDENT;
        tok_start_q = here;
        tok_len_q   = OFF_W'(1);
      end else if (digit) begin
        scan_mode_q = MODE_NUMBER;
        tok_start_q = here;
        tok_len_q   = OFF_W'(1);
        acc_q       = NUM_W'(b - CHAR_ZERO);
        acc_ovf_q   = 1'b0;
      end else if (oper) begin
        found.push_back(token_of(KIND_OPER, b, '0, 1'b0, here, OFF_W'(1)));
      end else if (b == CHAR_NEWLINE) begin
        found.push_back(token_of(KIND_NEWLINE, 8'h00, '0, 1'b0, here, OFF_W'(1)));
        line_q = sat_inc(line_q);
      end else if (b == CHAR_QUOTE) begin
        scan_mode_q = MODE_STRING;
        tok_start_q = sat_inc(here);
        tok_len_q   = '0;
      end else begin
        found.push_back(token_of(KIND_ERROR, b, '0, 1'b0, here, '0));
        scan_mode_q = MODE_DISCARD;
      end
    end

    // End of input restarts at line 1, offset 0
    if (restart) begin
      scan_mode_q = MODE_IDLE;
      acc_q       = '0;
      acc_ovf_q   = 1'b0;
      tok_start_q = '0;
      tok_len_q   = '0;
      pos_q       = '0;
      line_q      = OFF_W'(1);
    end else begin
      pos_q = sat_inc(pos_q);
    end

    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) pending_tokens.push_back(found[i]);
  endfunction

  // ------------------------------------------------------------------
  // Clock, watchdog
  // ------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Token sink: random stall bursts while idling is on
  // ------------------------------------------------------------------
  initial begin : token_sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        token_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        token_ready_i <= 1'b0;
      end else begin
        token_ready_i <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Token checker: compare every accepted beat with the oldest prediction
  // ------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [NUM_W-1:0] want,
                                      input logic [NUM_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && token_valid_o && token_ready_i) begin
      if (pending_tokens.size() == 0) begin
        errors++;
        $display("%0t: token with none predicted, expected none actual kind %0d",
                 $time, token_kind_o);
      end else begin
        seen_token = pending_tokens.pop_front();
        check_field("token_kind", NUM_W'(seen_token.kind), NUM_W'(token_kind_o));
        check_field("operator_char", NUM_W'(seen_token.op_char), NUM_W'(operator_char_o));
        check_field("number_value", seen_token.value, number_value_o);
        check_field("number_overflow", NUM_W'(seen_token.overflow),
                    NUM_W'(number_overflow_o));
        check_field("start_offset", NUM_W'(seen_token.start), NUM_W'(start_offset_o));
        check_field("text_length", NUM_W'(seen_token.length), NUM_W'(text_length_o));
        check_field("line_number", NUM_W'(seen_token.line), NUM_W'(line_number_o));
        check_field("last_result", NUM_W'(seen_token.last), NUM_W'(last_result_o));
      end
    end
  end

  // ------------------------------------------------------------------
  // Byte source
  // ------------------------------------------------------------------
  // Drive one byte, hold it until the beat is taken, then predict its tokens.
  // Called right after an edge; valid is touched once per time step.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      source_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    source_valid_i <= 1'b1;
    source_byte_i  <= b;
    do @(posedge clk_i); while (!source_ready_o);
    scan_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Every operator, whitespace skip, newline advancing the line count
  task automatic test_operators;
    send_text(",()+-*/ \t\n(");
    send_byte(CHAR_NUL);
  endtask

  // Identifiers ended by other tokens, numbers up to and past the 32-bit limit
  task automatic test_words_and_numbers;
    send_text("az 4294967295,4294967296 0x");
    send_byte(CHAR_NUL);
  endtask

  // Strings: newline in the body, high-bit bytes, empty body, no closing quote
  task automatic test_strings;
    send_text("\"a\n\t\"+");
    send_byte(CHAR_QUOTE);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text("\"\"\"\"ab");
    send_byte(CHAR_NUL);
  endtask

  // End right after a previous end, bad characters, dropped bytes up to the next end
  task automatic test_errors;
    send_byte(CHAR_NUL);
    send_text("ab#cd\n");
    send_byte(CHAR_NUL);
    send_byte(CHAR_NINE);
    send_byte(8'hFF);
    send_byte(CHAR_NUL);
  endtask

  // Mostly well-formed token streams with random content, some noise
  task automatic test_random_streams(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;

    target = scanned_bytes + count;
    while (scanned_bytes < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        len = $urandom_range(1, 8);
        repeat (len) send_byte(CHAR_A_LOW + 8'($urandom_range(0, 25)));
      end else if (pick < 40) begin
        // Mostly short numbers, sometimes long enough to saturate
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        repeat (len) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else if (pick < 52) begin
        send_byte(CHAR_QUOTE);
        len = $urandom_range(0, 6);
        repeat (len) begin
          b = 8'($urandom_range(1, 255));
          if (b == CHAR_QUOTE) b = CHAR_NEWLINE;
          send_byte(b);
        end
        if ($urandom_range(0, 9) == 0) send_byte(CHAR_NUL);
        else send_byte(CHAR_QUOTE);
      end else if (pick < 67) begin
        send_byte(oper_chars[$urandom_range(0, 6)]);
      end else if (pick < 75) begin
        send_byte(CHAR_NEWLINE);
      end else if (pick < 85) begin
        send_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      end else if (pick < 93) begin
        send_byte(CHAR_NUL);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    // Close whatever is open so the next part starts clean
    send_byte(CHAR_NUL);
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_operators;
    test_words_and_numbers;
    test_strings;
    test_errors;
    test_random_streams(430);
    // Calm tail: no gaps on either side
    idle_on = 1'b0;
    test_random_streams(150);

    source_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    // Allow for a stray token beyond the last prediction
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
